// ----- sv/position_head_frame_decoder_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the position head frame decoder
// Shared same-cycle implication and next-cycle checks on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef POSITION_HEAD_FRAME_DECODER_CORE_ASSERT_SVH
`define POSITION_HEAD_FRAME_DECODER_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define PHFD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("phfd: same-cycle check failed");

// Check that cons holds in the cycle after ante
`define PHFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("phfd: next-cycle check failed");

`endif

// ----- sv/phfd_pkg.sv -----
// ----------------------------------------------------------------------------
// phfd_pkg
// Constants and types for the position head frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package phfd_pkg;

  // Frame buffer
  localparam int FRAME_BYTES = 21;
  localparam int POS_W       = $clog2(FRAME_BYTES + 1);
  localparam int CSUM_BYTES  = 20;

  // Tag grid
  localparam int GRID_COLUMNS = 5;
  localparam int GRID_PITCH   = 10000;
  localparam int PITCH_W      = 14;
  localparam int RECIP_SHIFT  = 34;
  localparam int RECIP_W      = 35;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(GRID_COLUMNS) - 64'd1) / 64'(GRID_COLUMNS));
  localparam int REM_W = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;

  // Field widths
  localparam int TAG_W  = 28;
  localparam int WC_W   = 14;
  localparam int DEV_W  = 24;
  localparam int ANG_W  = 15;
  localparam int XW_W   = 25;
  localparam int YW_W   = 41;
  localparam int DATA_W = 192;
  localparam int USER_W = 3;

  // Angle constants in tenths of a degree
  localparam logic [15:0] ANGLE_RIGHT = 16'd900;
  localparam logic [15:0] ANGLE_FULL  = 16'd3600;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam logic CFG_IDX_KIND = 1'b0;

  // Expected reply kinds
  localparam logic [2:0] KIND_DATA  = 3'd0;
  localparam logic [2:0] KIND_BLUE  = 3'd1;
  localparam logic [2:0] KIND_GREEN = 3'd2;
  localparam logic [2:0] KIND_RED   = 3'd3;
  localparam logic [2:0] KIND_BEST  = 3'd4;
  localparam logic [2:0] KIND_LEFT  = 3'd5;
  localparam logic [2:0] KIND_RIGHT = 3'd6;
  localparam logic [2:0] KIND_RESET = KIND_BEST;

  // Acknowledge codes
  localparam logic [7:0] ACK_BLUE  = 8'h01;
  localparam logic [7:0] ACK_GREEN = 8'h02;
  localparam logic [7:0] ACK_RED   = 8'h04;
  localparam logic [7:0] ACK_BEST  = 8'h03;
  localparam logic [7:0] ACK_LEFT  = 8'h02;
  localparam logic [7:0] ACK_RIGHT = 8'h01;

  // Target classes
  localparam logic [1:0] CLS_NONE  = 2'd0;
  localparam logic [1:0] CLS_CODE  = 2'd1;
  localparam logic [1:0] CLS_COLOR = 2'd2;
  localparam logic [1:0] CLS_TAG   = 2'd3;

  // One decoded frame as it moves down the pipeline
  typedef struct packed {
    logic              ok;
    logic              pos;
    logic [1:0]        cls;
    logic              wflag;
    logic [WC_W-1:0]   wcode;
    logic [TAG_W-1:0]  tag;
    logic [DEV_W-1:0]  xdev;
    logic [DEV_W-1:0]  ydev;
    logic [ANG_W-1:0]  adev;
  } item_t;

endpackage

`default_nettype wire

// ----- sv/position_head_frame_decoder_core.sv -----
// ----------------------------------------------------------------------------
// position_head_frame_decoder_core
// Pipeline: a result reaches out_tvalid through the decode, reciprocal divide by the
//   grid width, grid multiply and world pose registers after its frame-end byte transfers.
// Throughput: one byte per cycle while out_tready does not stall; a frame may end on every byte.
// Reset (rst_n, synchronous): frame buffer, pose state and pipeline valid bits cleared,
//   reply_kind set to best track.
// ----------------------------------------------------------------------------
`default_nettype none

`include "position_head_frame_decoder_core_assert.svh"

module position_head_frame_decoder_core import phfd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input bytes: tdata = rx_byte[7:0]; tlast = frame_end
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,
  input  wire logic                  in_tlast,
  // results: tdata = warn_bit[0], warn_code[14:1], tag_or_code[42:15],
  //   x_dev[66:43], y_dev[90:67], angle_dev[105:91], x_coord[130:106],
  //   y_coord[171:131], angle_coord[186:172], zero fill[191:187]
  // tuser = reply_ok[0], target_kind[2:1]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [DATA_W-1:0]          out_tdata,
  output logic [USER_W-1:0]          out_tuser,
  // configuration
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  // State
  logic [7:0]       bytes_r [FRAME_BYTES];
  logic [POS_W-1:0] pos_r;
  logic [2:0]       kind_r;
  logic [1:0]       cls_r;
  logic [DEV_W-1:0] xdev_r, ydev_r;
  logic [ANG_W-1:0] adev_r;
  logic [XW_W-1:0]  xw_r;
  logic [YW_W-1:0]  yw_r;
  logic [ANG_W-1:0] aw_r;

  // Pipeline
  logic             v1_r, v2_r, v3_r, out_valid_r;
  item_t            s1_r, s2_r, s3_r, out_r;
  logic [TAG_W-1:0] q2_r;
  logic [REM_W-1:0] r3_r;
  logic [YW_W-1:0]  yprod3_r;
  logic [XW_W-1:0]  out_xw_r;
  logic [YW_W-1:0]  out_yw_r;
  logic [ANG_W-1:0] out_aw_r;

  logic en1, en2, en3, en_out;
  logic in_xfer, fe_xfer, cfg_wr;

  // Decode view
  logic [7:0]       view [FRAME_BYTES];
  logic [7:0]       csum;
  logic             csum_ok, ok_pos, ok_any;
  logic [1:0]       cls_new;
  logic [23:0]      xr;
  logic [13:0]      yr, ar;
  logic [TAG_W-1:0] raw_tag, tag_new;
  logic [DEV_W-1:0] xdev_new, ydev_new;
  logic [15:0]      a16, awrap;
  item_t            item_nxt;

  // Stage arithmetic
  logic [TAG_W+RECIP_W-1:0] qprod;
  logic [TAG_W-1:0]         rem_full;
  logic [XW_W-1:0]          xw_nxt;
  logic [YW_W-1:0]          yw_nxt;
  logic [ANG_W-1:0]         aw_nxt;

  // Handshake and stall chain
  assign en_out    = !out_valid_r || out_tready;
  assign en3       = !v3_r || en_out;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;
  assign in_xfer   = in_tvalid && in_tready;
  assign fe_xfer   = in_xfer && in_tlast;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_KIND) ? {29'd0, kind_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == CFG_IDX_KIND)) begin
      kind_r <= cfg_pwdata[2:0];
    end
  end

  // Merge the incoming byte into the stored frame
  always_comb begin
    for (int i = 0; i < FRAME_BYTES; i++) begin
      view[i] = (pos_r == POS_W'(i)) ? in_tdata : bytes_r[i];
    end
  end

  // Checksum over the data bytes
  always_comb begin
    csum = 8'd0;
    for (int i = 0; i < CSUM_BYTES; i++) begin
      csum = csum ^ view[i];
    end
  end
  assign csum_ok = (csum == view[CSUM_BYTES]);

  // Reply check by expected kind
  always_comb begin
    ok_pos = 1'b0;
    ok_any = 1'b0;
    unique case (kind_r)
      KIND_DATA: begin
        ok_pos = csum_ok;
        ok_any = csum_ok;
      end
      KIND_BLUE:  ok_any = (view[0] == view[1]) && (view[0] == ACK_BLUE);
      KIND_GREEN: ok_any = (view[0] == view[1]) && (view[0] == ACK_GREEN);
      KIND_RED:   ok_any = (view[0] == view[1]) && (view[0] == ACK_RED);
      KIND_BEST:  ok_any = (view[2] == (view[0] ^ view[1])) && (view[1] == ACK_BEST);
      KIND_LEFT:  ok_any = (view[2] == (view[0] ^ view[1])) && (view[1] == ACK_LEFT);
      KIND_RIGHT: ok_any = (view[2] == (view[0] ^ view[1])) && (view[1] == ACK_RIGHT);
      default:    ok_any = 1'b0;
    endcase
  end

  // Target class
  always_comb begin
    if (view[1][6]) begin
      cls_new = CLS_TAG;
    end else begin
      unique case ({view[1][2], view[0][1]})
        2'b01:   cls_new = CLS_COLOR;
        2'b11:   cls_new = CLS_NONE;
        default: cls_new = CLS_CODE;
      endcase
    end
  end

  // Packed 7-bit fields
  assign xr      = {view[2][2:0], view[3][6:0], view[4][6:0], view[5][6:0]};
  assign yr      = {view[6][6:0], view[7][6:0]};
  assign ar      = {view[10][6:0], view[11][6:0]};
  assign raw_tag = {view[14][6:0], view[15][6:0], view[16][6:0], view[17][6:0]};
  assign tag_new = view[0][3] ? {14'd0, raw_tag[TAG_W-1:14]} : raw_tag;

  // Deviations by class, then wrap a negative angle once
  always_comb begin
    xdev_new = xdev_r;
    ydev_new = ydev_r;
    a16      = {adev_r[ANG_W-1], adev_r};
    if (ok_pos) begin
      unique case (cls_new)
        CLS_COLOR: begin
          xdev_new = {{10{yr[13]}}, yr};
          ydev_new = '0;
          a16      = ANGLE_RIGHT - {{2{ar[13]}}, ar};
        end
        CLS_CODE: begin
          xdev_new = 24'd0 - {{10{yr[13]}}, yr};
          ydev_new = xr;
          a16      = ANGLE_RIGHT - {{2{ar[13]}}, ar};
        end
        CLS_TAG: begin
          xdev_new = xr;
          ydev_new = {{10{yr[13]}}, yr};
          a16      = 16'd0 - {{2{ar[13]}}, ar};
        end
        default: begin
          xdev_new = xdev_r;
        end
      endcase
    end
    awrap = a16[15] ? (a16 + ANGLE_FULL) : a16;
  end

  // Assemble the result for the pipeline
  always_comb begin
    item_nxt.ok    = ok_any;
    item_nxt.pos   = ok_pos;
    item_nxt.cls   = ok_pos ? cls_new : cls_r;
    item_nxt.wflag = ok_pos ? view[0][2] : 1'b0;
    item_nxt.wcode = ok_pos ? {view[18][6:0], view[19][6:0]} : '0;
    item_nxt.tag   = ok_pos ? tag_new : '0;
    item_nxt.xdev  = xdev_new;
    item_nxt.ydev  = ydev_new;
    item_nxt.adev  = ok_pos ? awrap[ANG_W-1:0] : adev_r;
  end

  // Frame buffer and byte position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        bytes_r[i] <= 8'd0;
      end
    end else if (in_xfer) begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
        bytes_r[i] <= view[i];
      end
      if (in_tlast) begin
        pos_r <= '0;
      end else if (pos_r < POS_W'(FRAME_BYTES)) begin
        pos_r <= pos_r + POS_W'(1);
      end
    end
  end

  // Pose deviation state, updated when a frame closes with a good data reply
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r  <= CLS_NONE;
      xdev_r <= '0;
      ydev_r <= '0;
      adev_r <= '0;
    end else if (fe_xfer && ok_pos) begin
      cls_r  <= item_nxt.cls;
      xdev_r <= item_nxt.xdev;
      ydev_r <= item_nxt.ydev;
      adev_r <= item_nxt.adev;
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1)    v1_r        <= fe_xfer;
      if (en2)    v2_r        <= v1_r;
      if (en3)    v3_r        <= v2_r;
      if (en_out) out_valid_r <= v3_r;
    end
  end

  // Divide the tag number by the grid width through its reciprocal
  assign qprod    = {{RECIP_W{1'b0}}, s1_r.tag} * {{TAG_W{1'b0}}, RECIP};
  assign rem_full = s2_r.tag - TAG_W'(q2_r * TAG_W'(GRID_COLUMNS));

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_r <= item_nxt;
    end
    if (en2) begin
      s2_r <= s1_r;
      q2_r <= qprod[RECIP_SHIFT +: TAG_W];
    end
    if (en3) begin
      s3_r     <= s2_r;
      r3_r     <= rem_full[REM_W-1:0];
      yprod3_r <= {{(YW_W-TAG_W){1'b0}}, q2_r} * YW_W'(GRID_PITCH);
    end
    if (en_out) begin
      out_r    <= s3_r;
      out_xw_r <= xw_nxt;
      out_yw_r <= yw_nxt;
      out_aw_r <= aw_nxt;
    end
  end

  // World pose: tag adds the grid cell, code tape copies, others hold
  always_comb begin
    xw_nxt = xw_r;
    yw_nxt = yw_r;
    aw_nxt = aw_r;
    if (v3_r && s3_r.pos) begin
      priority if (s3_r.cls == CLS_TAG) begin
        xw_nxt = ({{(XW_W-REM_W){1'b0}}, r3_r} * XW_W'(GRID_PITCH))
                 + {s3_r.xdev[DEV_W-1], s3_r.xdev};
        yw_nxt = yprod3_r + {{(YW_W-DEV_W){s3_r.ydev[DEV_W-1]}}, s3_r.ydev};
        aw_nxt = s3_r.adev;
      end else if (s3_r.cls == CLS_CODE) begin
        xw_nxt = {s3_r.xdev[DEV_W-1], s3_r.xdev};
        yw_nxt = {{(YW_W-DEV_W){s3_r.ydev[DEV_W-1]}}, s3_r.ydev};
        aw_nxt = s3_r.adev;
      end else begin
        aw_nxt = aw_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xw_r <= '0;
      yw_r <= '0;
      aw_r <= '0;
    end else if (en_out && v3_r) begin
      xw_r <= xw_nxt;
      yw_r <= yw_nxt;
      aw_r <= aw_nxt;
    end
  end

  // Result channel
  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_r.cls, out_r.ok};
  assign out_tdata  = {5'd0, out_aw_r, out_yw_r, out_xw_r, out_r.adev, out_r.ydev,
                       out_r.xdev, out_r.tag, out_r.wcode, out_r.wflag};

  // Checks
  `PHFD_ASSERT_IMPL(a_pos_bound, 1'b1, pos_r <= POS_W'(FRAME_BYTES))
  `PHFD_ASSERT_NEXT(a_pos_clear, in_tvalid && in_tready && in_tlast, pos_r == '0)
  `PHFD_ASSERT_IMPL(a_stall_full, !in_tready, v1_r && v2_r && v3_r && out_valid_r)
  `PHFD_ASSERT_IMPL(a_fail_clear, out_valid_r && !out_r.pos,
                    !out_r.wflag && (out_r.wcode == '0) && (out_r.tag == '0))

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: position head frame decoder testbench
// Streams reply bytes into the decoder under each expected reply kind and
// compares every decoded result against an in-bench pose predictor. A short
// hand-written frame table covers acknowledge codes, checksum failures,
// target classes and field extremes; random frames follow, with gaps and
// stalls on both streams.
// ----------------------------------------------------------------------------
module tb import phfd_pkg::*; ();

  localparam int ITEM_TARGET  = 1850;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_FRAME    = 24;
  localparam logic [2:0] KIND_UNUSED = 3'd7;
  localparam logic [CFG_ADDR_W-1:0] KIND_ADDR = CFG_ADDR_W'(4 * CFG_IDX_KIND);
  localparam longint RIGHT_TENTHS = longint'(ANGLE_RIGHT);
  localparam longint FULL_TENTHS  = longint'(ANGLE_FULL);

  // One decoded reply as seen on the result stream
  typedef struct packed {
    logic             ok;
    logic [1:0]       kind;
    logic             wflag;
    logic [WC_W-1:0]  wcode;
    logic [TAG_W-1:0] tag;
    logic [DEV_W-1:0] xdev;
    logic [DEV_W-1:0] ydev;
    logic [ANG_W-1:0] adev;
    logic [XW_W-1:0]  xw;
    logic [YW_W-1:0]  yw;
    logic [ANG_W-1:0] aw;
  } pose_result_t;

  // One hand-written frame: bytes listed first byte first
  typedef struct packed {
    logic [2:0]   kind;
    int           len;
    bit           seal;
    logic [191:0] bytes;
    int           typed_ok;
  } frame_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [DATA_W-1:0]     out_tdata;
  logic [USER_W-1:0]     out_tuser;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  // Predictor state
  logic [7:0]  rx_frame [FRAME_BYTES];
  int          rx_count;
  logic [1:0]  pose_class;
  longint      dev_x, dev_y, dev_ang;
  longint      world_x, world_y, world_ang;
  logic [2:0]  expected_kind;

  pose_result_t pose_expect_q [$];
  frame_row_t   stim_table [$];
  logic [7:0]   tx_frame [MAX_FRAME];
  int           mismatches = 0;
  int unsigned  cycle_count = 0;
  bit           in_gaps = 0;
  bit           ready_gaps = 0;

  position_head_frame_decoder_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // End the run if it hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Store one byte by position; on frame end decode and return the result
  function automatic bit decode_rx_byte(input logic [7:0] b, input logic last,
                                        output pose_result_t r);
    logic [7:0]         sum;
    logic signed [23:0] x_raw;
    logic signed [13:0] y_raw, a_raw;
    logic [TAG_W-1:0]   raw, tag;
    logic               ok, wf;
    logic [WC_W-1:0]    wc;
    longint             xv, yv, av, tn;
    ok = 1'b0;
    wf = 1'b0;
    wc = '0;
    tag = '0;
    r = '0;
    if (rx_count < FRAME_BYTES) begin
      rx_frame[rx_count] = b;
      rx_count++;
    end
    if (!last) return 1'b0;
    rx_count = 0;
    case (expected_kind)
      KIND_DATA: begin
        sum = 8'h00;
        for (int i = 0; i < CSUM_BYTES; i++) sum ^= rx_frame[i];
        if (sum == rx_frame[CSUM_BYTES]) begin
          ok = 1'b1;
          wf = rx_frame[0][2];
          wc = {rx_frame[18][6:0], rx_frame[19][6:0]};
          // classify: tag bit wins, else color bit in byte 0 and none bit in byte 1
          if (rx_frame[1][6]) pose_class = CLS_TAG;
          else if (rx_frame[0][1] && !rx_frame[1][2]) pose_class = CLS_COLOR;
          else if (rx_frame[0][1] && rx_frame[1][2]) pose_class = CLS_NONE;
          else pose_class = CLS_CODE;
          x_raw = {rx_frame[2][2:0], rx_frame[3][6:0], rx_frame[4][6:0], rx_frame[5][6:0]};
          y_raw = {rx_frame[6][6:0], rx_frame[7][6:0]};
          a_raw = {rx_frame[10][6:0], rx_frame[11][6:0]};
          raw = {rx_frame[14][6:0], rx_frame[15][6:0], rx_frame[16][6:0], rx_frame[17][6:0]};
          tag = rx_frame[0][3] ? TAG_W'(raw[27:14]) : raw;
          xv = x_raw;
          yv = y_raw;
          av = a_raw;
          tn = tag;
          case (pose_class)
            CLS_COLOR: begin
              dev_x = yv;
              dev_y = 0;
              dev_ang = RIGHT_TENTHS - av;
            end
            CLS_CODE: begin
              dev_x = -yv;
              dev_y = xv;
              dev_ang = RIGHT_TENTHS - av;
            end
            CLS_TAG: begin
              dev_x = xv;
              dev_y = yv;
              dev_ang = -av;
            end
            default: ;
          endcase
          // wrap negative heading once, also when it was kept
          if (dev_ang < 0) dev_ang += FULL_TENTHS;
          if (pose_class == CLS_TAG) begin
            world_x = (tn % GRID_COLUMNS) * GRID_PITCH + dev_x;
            world_y = (tn / GRID_COLUMNS) * GRID_PITCH + dev_y;
            world_ang = dev_ang;
          end else if (pose_class == CLS_CODE) begin
            world_x = dev_x;
            world_y = dev_y;
            world_ang = dev_ang;
          end
        end
      end
      KIND_BLUE:  ok = rx_frame[0] == rx_frame[1] && rx_frame[0] == ACK_BLUE;
      KIND_GREEN: ok = rx_frame[0] == rx_frame[1] && rx_frame[0] == ACK_GREEN;
      KIND_RED:   ok = rx_frame[0] == rx_frame[1] && rx_frame[0] == ACK_RED;
      KIND_BEST:  ok = rx_frame[2] == (rx_frame[0] ^ rx_frame[1]) && rx_frame[1] == ACK_BEST;
      KIND_LEFT:  ok = rx_frame[2] == (rx_frame[0] ^ rx_frame[1]) && rx_frame[1] == ACK_LEFT;
      KIND_RIGHT: ok = rx_frame[2] == (rx_frame[0] ^ rx_frame[1]) && rx_frame[1] == ACK_RIGHT;
      default:    ok = 1'b0;
    endcase
    r.ok    = ok;
    r.kind  = pose_class;
    r.wflag = wf;
    r.wcode = wc;
    r.tag   = tag;
    r.xdev  = dev_x[DEV_W-1:0];
    r.ydev  = dev_y[DEV_W-1:0];
    r.adev  = dev_ang[ANG_W-1:0];
    r.xw    = world_x[XW_W-1:0];
    r.yw    = world_y[YW_W-1:0];
    r.aw    = world_ang[ANG_W-1:0];
    return 1'b1;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h7F;
      3: return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Put the XOR of the checksummed bytes into the checksum byte
  function automatic void seal_checksum();
    logic [7:0] sum;
    sum = 8'h00;
    for (int i = 0; i < CSUM_BYTES; i++) sum ^= tx_frame[i];
    tx_frame[CSUM_BYTES] = sum;
  endfunction

  function automatic frame_row_t make_row(logic [2:0] kind, int len, bit seal,
                                          logic [191:0] bytes, int typed_ok);
    frame_row_t row;
    row.kind = kind;
    row.len = len;
    row.seal = seal;
    row.bytes = bytes;
    row.typed_ok = typed_ok;
    return row;
  endfunction

  // Transfer one byte; typed_ok overrides the predicted ok flag when not negative
  task automatic send_byte(input logic [7:0] b, input logic last, input int typed_ok);
    pose_result_t r;
    if (in_gaps && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    if (decode_rx_byte(b, last, r)) begin
      if (typed_ok >= 0) r.ok = typed_ok[0];
      pose_expect_q.push_back(r);
    end
  endtask

  task automatic send_frame(input int len, input int typed_ok, input bit closes);
    for (int i = 0; i < len; i++)
      send_byte(tx_frame[i], closes && i == len - 1, (i == len - 1) ? typed_ok : -1);
  endtask

  // Hold the input and wait until every pending result has come out
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pose_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_reply_kind();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= KIND_ADDR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    check_field("reply_kind readback", 64'(expected_kind), 64'(cfg_prdata));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_reply_kind(input logic [2:0] k);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= KIND_ADDR;
    cfg_pwdata  <= 32'(k);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    expected_kind = k;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    check_reply_kind();
  endtask

  // Random result-side stalls in bursts
  initial begin
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (ready_gaps && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest expected pose
  always @(posedge clk) begin : result_check
    pose_result_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.ok    = out_tuser[0];
      got.kind  = out_tuser[2:1];
      got.wflag = out_tdata[0];
      got.wcode = out_tdata[14:1];
      got.tag   = out_tdata[42:15];
      got.xdev  = out_tdata[66:43];
      got.ydev  = out_tdata[90:67];
      got.adev  = out_tdata[105:91];
      got.xw    = out_tdata[130:106];
      got.yw    = out_tdata[171:131];
      got.aw    = out_tdata[186:172];
      if (pose_expect_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual tuser 0x%0h tdata 0x%0h",
                 $time, out_tuser, out_tdata);
        mismatches++;
      end else begin
        want = pose_expect_q.pop_front();
        check_field("reply_ok", 64'(want.ok), 64'(got.ok));
        check_field("target_kind", 64'(want.kind), 64'(got.kind));
        check_field("warn_bit", 64'(want.wflag), 64'(got.wflag));
        check_field("warn_code", 64'(want.wcode), 64'(got.wcode));
        check_field("tag_or_code", 64'(want.tag), 64'(got.tag));
        check_field("x_dev", 64'(want.xdev), 64'(got.xdev));
        check_field("y_dev", 64'(want.ydev), 64'(got.ydev));
        check_field("angle_dev", 64'(want.adev), 64'(got.adev));
        check_field("x_coord", 64'(want.xw), 64'(got.xw));
        check_field("y_coord", 64'(want.yw), 64'(got.yw));
        check_field("angle_coord", 64'(want.aw), 64'(got.aw));
      end
    end
  end

  initial begin
    frame_row_t row;
    int         total, phase_len, phase_sent, mode, len;
    logic [2:0] k;
    logic [7:0] code;
    bit         closes;

    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= 8'h00;
    in_tlast    <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= 32'h0;

    // Predictor state after reset
    for (int i = 0; i < FRAME_BYTES; i++) rx_frame[i] = 8'h00;
    rx_count = 0;
    pose_class = CLS_NONE;
    dev_x = 0;
    dev_y = 0;
    dev_ang = 0;
    world_x = 0;
    world_y = 0;
    world_ang = 0;
    expected_kind = KIND_RESET;

    // Directed frames: acknowledge codes, bad replies, target classes, extremes
    stim_table.push_back(make_row(KIND_BEST, 3, 0, {8'h01, 8'h03, 8'h02}, 1));
    stim_table.push_back(make_row(KIND_BEST, 3, 0, {8'h01, 8'h03, 8'h03}, 0));
    stim_table.push_back(make_row(KIND_BEST, 1, 0, {8'hFF}, -1));
    stim_table.push_back(make_row(KIND_LEFT, 3, 0, {8'h00, 8'h02, 8'h02}, 1));
    stim_table.push_back(make_row(KIND_RIGHT, 3, 0, {8'hFF, 8'h01, 8'hFE}, 1));
    stim_table.push_back(make_row(KIND_RIGHT, 3, 0, {8'h80, 8'h81, 8'h01}, 0));
    stim_table.push_back(make_row(KIND_BLUE, 2, 0, {8'h01, 8'h01}, 1));
    stim_table.push_back(make_row(KIND_GREEN, 2, 0, {8'h02, 8'h02}, 1));
    stim_table.push_back(make_row(KIND_RED, 2, 0, {8'h04, 8'h04}, 1));
    stim_table.push_back(make_row(KIND_RED, 2, 0, {8'h04, 8'h84}, 0));
    stim_table.push_back(make_row(KIND_UNUSED, 3, 0, {8'h04, 8'h04, 8'h00}, 0));
    // tag with control flag and warning, positive extremes, most negative angle
    stim_table.push_back(make_row(KIND_DATA, 21, 1,
      {8'h0C, 8'h40, 8'h03, 8'h7F, 8'h7F, 8'h7F, 8'h3F, 8'h7F, 8'h00, 8'h00, 8'h40,
       8'h00, 8'h00, 8'h00, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h00}, 1));
    // tag at the largest number, negative extremes, heading wraps to its lowest
    stim_table.push_back(make_row(KIND_DATA, 21, 1,
      {8'h00, 8'h40, 8'h04, 8'h00, 8'h00, 8'h00, 8'h40, 8'h00, 8'h00, 8'h00, 8'h1F,
       8'h7F, 8'h00, 8'h00, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h80, 8'h80, 8'h00}, 1));
    // code tape, both selector forms
    stim_table.push_back(make_row(KIND_DATA, 21, 1,
      {8'h00, 8'h00, 8'h02, 8'h11, 8'h22, 8'h33, 8'h7F, 8'h70, 8'h00, 8'h00, 8'h00,
       8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h09, 8'h01, 8'h02, 8'h00}, 1));
    stim_table.push_back(make_row(KIND_DATA, 21, 1,
      {8'h00, 8'h04, 8'h05, 8'h7F, 8'h00, 8'h55, 8'h12, 8'h34, 8'h00, 8'h00, 8'h1F,
       8'h7F, 8'h00, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h00, 8'h00, 8'h00}, 1));
    // colored tape with the largest heading
    stim_table.push_back(make_row(KIND_DATA, 21, 1,
      {8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h40, 8'h01, 8'h00, 8'h00, 8'h20,
       8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h05, 8'h00, 8'h00, 8'h00}, 1));
    // no target: pose is kept
    stim_table.push_back(make_row(KIND_DATA, 21, 1,
      {8'h02, 8'h04, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h00, 8'h00, 8'h07,
       8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1));
    // checksum failure
    stim_table.push_back(make_row(KIND_DATA, 21, 0, {8'h01, {20{8'h00}}}, 0));
    // every bit set, high bits must be masked
    stim_table.push_back(make_row(KIND_DATA, 21, 1, {21{8'hFF}}, 1));
    // short frame reuses older bytes
    stim_table.push_back(make_row(KIND_DATA, 5, 0, {8'h00, 8'h40, 8'h00, 8'h00, 8'h00}, -1));
    // overlong frame: trailing bytes are dropped
    stim_table.push_back(make_row(KIND_DATA, 24, 1,
      {8'h00, 8'h40, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00,
       8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0C, 8'h00, 8'h00, 8'h00, 8'hAA,
       8'h55, 8'hAA}, 1));
    // frame end on a single byte
    stim_table.push_back(make_row(KIND_DATA, 1, 0, {8'h00}, -1));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_reply_kind();

    in_gaps = 1;
    ready_gaps = 1;
    foreach (stim_table[r]) begin
      row = stim_table[r];
      if (row.kind != expected_kind) begin
        settle();
        set_reply_kind(row.kind);
      end
      for (int i = 0; i < row.len; i++) tx_frame[i] = row.bytes[8 * (row.len - 1 - i) +: 8];
      if (row.seal) seal_checksum();
      send_frame(row.len, row.typed_ok, 1);
    end

    // Random phases, each under its own reply kind and idling mix
    total = 0;
    while (total < ITEM_TARGET) begin
      mode = $urandom_range(0, 19);
      if (mode == 0) k = KIND_UNUSED;
      else if (mode < 9) k = KIND_DATA;
      else k = 3'($urandom_range(1, 6));
      settle();
      set_reply_kind(k);
      in_gaps = $urandom_range(0, 3) != 0;
      ready_gaps = $urandom_range(0, 3) != 0;
      phase_len = $urandom_range(120, 260);
      phase_sent = 0;
      while (phase_sent < phase_len && total < ITEM_TARGET) begin
        // quiet stretch at the end of the run
        if (total >= ITEM_TARGET - 250) begin
          in_gaps = 0;
          ready_gaps = 0;
        end
        for (int i = 0; i < MAX_FRAME; i++) tx_frame[i] = pick_byte();
        closes = 1;
        mode = $urandom_range(0, 19);
        if (k == KIND_DATA) begin
          len = FRAME_BYTES;
          if (mode < 16) seal_checksum();
          if (mode == 14 || mode == 15) tx_frame[CSUM_BYTES] ^= 8'($urandom_range(1, 255));
          if (mode == 16 || mode == 17) len = $urandom_range(1, FRAME_BYTES - 1);
          if (mode == 18) begin
            seal_checksum();
            len = $urandom_range(FRAME_BYTES + 1, MAX_FRAME);
          end
          if (mode == 19) begin
            len = $urandom_range(1, 5);
            closes = 0;
          end
        end else if (k == KIND_UNUSED || mode >= 14) begin
          len = $urandom_range(1, 6);
          if (mode == 19) closes = 0;
        end else begin
          case (k)
            KIND_BLUE:  code = ACK_BLUE;
            KIND_GREEN: code = ACK_GREEN;
            KIND_RED:   code = ACK_RED;
            KIND_BEST:  code = ACK_BEST;
            KIND_LEFT:  code = ACK_LEFT;
            default:    code = ACK_RIGHT;
          endcase
          tx_frame[1] = code;
          if (k <= KIND_RED) begin
            tx_frame[0] = code;
            len = $urandom_range(2, 4);
          end else begin
            tx_frame[2] = tx_frame[0] ^ tx_frame[1];
            len = $urandom_range(3, 4);
          end
          // near miss: flip one bit of the acknowledge bytes
          if (mode >= 12) tx_frame[$urandom_range(0, 2)] ^= 8'(1 << $urandom_range(0, 7));
        end
        send_frame(len, -1, closes);
        total += len;
        phase_sent += len;
      end
    end

    settle();
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/phfd_pkg.sv
sv/position_head_frame_decoder_core.sv
tb/tb.sv
